// ----- rtl/udcp_pkg.sv -----
// udcp_pkg: shared types and constants for the UART drive command parser.
// No dependencies; every other file of the block but udcp_if refers to it by scoped names.
package udcp_pkg;

    // input word kinds
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_ERROR = 2'd2
    } cmd_t;

    // result actions
    typedef enum logic [1:0] {
        ACT_SET_TARGETS = 2'd0,
        ACT_STOP_CMD    = 2'd1,
        ACT_STOP_WDOG   = 2'd2
    } action_t;

    // APB register map: index is paddr[2]
    localparam int PADDR_W = 3;
    localparam logic REG_TIMEOUT_IDX = 1'b0;
    localparam logic REG_ENABLE_IDX  = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic        ENABLE_RESET  = 1'b1;

    localparam int ELAPSED_W = 17;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_V     = 8'h56;

    // STOP keyword matcher
    localparam logic [2:0] STOP_DONE   = 3'd4;
    localparam logic [2:0] STOP_FAILED = 3'd5;

    function automatic logic [7:0] stop_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h53;  // S
            2'd1:    ch = 8'h54;  // T
            2'd2:    ch = 8'h4F;  // O
            default: ch = 8'h50;  // P
        endcase
        return ch;
    endfunction

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic        enable;
    } cfg_t;

    // line-end events from the parser
    typedef struct packed {
        logic set_cmd;
        logic stop_cmd;
    } parse_evt_t;

endpackage

// ----- rtl/udcp_if.sv -----
// udcp_if: valid/ready channel interfaces for input words and result words.
// Depends on nothing; widths of the result targets follow TARGET_BITS.
interface udcp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, command, rx_byte, input ready);
    modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface udcp_out_if #(
    parameter int TARGET_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic signed [TARGET_BITS-1:0] left_target;
    logic signed [TARGET_BITS-1:0] right_target;

    modport source (output valid, action, left_target, right_target, input ready);
    modport sink   (input valid, action, left_target, right_target, output ready);
endinterface

// ----- rtl/udcp_apb_regs.sv -----
// udcp_apb_regs: APB register file holding watchdog timeout and enable.
// Depends on udcp_pkg.
module udcp_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [udcp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output udcp_pkg::cfg_t              cfg
);

    logic [15:0] timeout_reg;
    logic        enable_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= udcp_pkg::TIMEOUT_RESET;
            enable_reg  <= udcp_pkg::ENABLE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                udcp_pkg::REG_TIMEOUT_IDX: timeout_reg <= pwdata[15:0];
                default:                   enable_reg  <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            udcp_pkg::REG_TIMEOUT_IDX: prdata = {16'd0, timeout_reg};
            default:                   prdata = {31'd0, enable_reg};
        endcase
    end

    assign cfg.timeout_ms = timeout_reg;
    assign cfg.enable     = enable_reg;

endmodule

// ----- rtl/udcp_line_parser.sv -----
// udcp_line_parser: incremental per-byte parse of V,<int>,<int> and STOP lines.
// Depends on udcp_pkg; emits line-end events and the saturated targets.
module udcp_line_parser #(
    parameter int LINE_CAPACITY = 64,
    parameter int TARGET_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [1:0]                    command,
    input  logic [7:0]                    rx_byte,
    output udcp_pkg::parse_evt_t          evt,
    output logic signed [TARGET_BITS-1:0] left_target,
    output logic signed [TARGET_BITS-1:0] right_target
);

    localparam int FILL_W = $clog2(LINE_CAPACITY);
    localparam int WIDE_W = TARGET_BITS + 4;
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(LINE_CAPACITY - 1);
    localparam logic [TARGET_BITS-1:0] LIMIT = {1'b1, {(TARGET_BITS-1){1'b0}}};
    localparam logic [TARGET_BITS-1:0] POS_MAX = LIMIT - 1'b1;

    typedef enum logic [9:0] {
        PH_EXPECT_V     = 10'b00_0000_0001,
        PH_EXPECT_COMMA = 10'b00_0000_0010,
        PH_LEFT_START   = 10'b00_0000_0100,
        PH_LEFT_SIGN    = 10'b00_0000_1000,
        PH_LEFT_DIGITS  = 10'b00_0001_0000,
        PH_RIGHT_START  = 10'b00_0010_0000,
        PH_RIGHT_SIGN   = 10'b00_0100_0000,
        PH_RIGHT_DIGITS = 10'b00_1000_0000,
        PH_MATCHED      = 10'b01_0000_0000,
        PH_FAILED       = 10'b10_0000_0000
    } phase_t;

    // mag*10 + digit, capped at 2^(TARGET_BITS-1)
    function automatic logic [TARGET_BITS-1:0] add_digit(
        input logic [TARGET_BITS-1:0] mag,
        input logic [7:0]             ch
    );
        logic [WIDE_W-1:0] wide;
        wide = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {{TARGET_BITS{1'b0}}, ch[3:0]};
        return (wide > {4'd0, LIMIT}) ? LIMIT : wide[TARGET_BITS-1:0];
    endfunction

    function automatic logic [TARGET_BITS-1:0] to_target(
        input logic [TARGET_BITS-1:0] mag,
        input logic                   neg
    );
        logic [TARGET_BITS-1:0] res;
        if (neg)
            res = ~mag + 1'b1;  // mag never exceeds LIMIT
        else
            res = (mag > POS_MAX) ? POS_MAX : mag;
        return res;
    endfunction

    phase_t                 phase_reg, phase_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [TARGET_BITS-1:0] lmag_reg, lmag_next, rmag_reg, rmag_next;
    logic                   lneg_reg, lneg_next, rneg_reg, rneg_next;
    logic [2:0]             stop_reg, stop_next;
    logic                   ended_reg, ended_next;

    logic is_blank, is_digit, is_sign, is_minus;

    assign is_blank = (rx_byte == udcp_pkg::CH_SPACE) || (rx_byte == udcp_pkg::CH_TAB)
                   || (rx_byte == udcp_pkg::CH_VT) || (rx_byte == udcp_pkg::CH_FF);
    assign is_digit = (rx_byte >= udcp_pkg::CH_ZERO) && (rx_byte <= udcp_pkg::CH_NINE);
    assign is_minus = (rx_byte == udcp_pkg::CH_MINUS);
    assign is_sign  = is_minus || (rx_byte == udcp_pkg::CH_PLUS);

    assign left_target  = to_target(lmag_reg, lneg_reg);
    assign right_target = to_target(rmag_reg, rneg_reg);

    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        lmag_next  = lmag_reg;
        lneg_next  = lneg_reg;
        rmag_next  = rmag_reg;
        rneg_next  = rneg_reg;
        stop_next  = stop_reg;
        ended_next = ended_reg;
        evt        = '0;

        if (take && (command == udcp_pkg::CMD_ERROR))
        begin
            phase_next = PH_EXPECT_V;
            fill_next  = '0;
            lmag_next  = '0;
            lneg_next  = 1'b0;
            rmag_next  = '0;
            rneg_next  = 1'b0;
            stop_next  = '0;
            ended_next = 1'b0;
        end
        else if (take && (command == udcp_pkg::CMD_BYTE) && (rx_byte != udcp_pkg::CH_CR))
        begin
            if ((rx_byte == udcp_pkg::CH_LF) || (fill_reg == FILL_LAST))
            begin
                // line end or overflow: judge (line feed only) and clear
                if ((rx_byte == udcp_pkg::CH_LF) && (fill_reg != '0))
                begin
                    evt.set_cmd  = (phase_reg == PH_RIGHT_DIGITS) || (phase_reg == PH_MATCHED);
                    evt.stop_cmd = !evt.set_cmd && (stop_reg == udcp_pkg::STOP_DONE);
                end
                phase_next = PH_EXPECT_V;
                fill_next  = '0;
                lmag_next  = '0;
                lneg_next  = 1'b0;
                rmag_next  = '0;
                rneg_next  = 1'b0;
                stop_next  = '0;
                ended_next = 1'b0;
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
                if (!ended_reg && (rx_byte == udcp_pkg::CH_NUL))
                    ended_next = 1'b1;
                else if (!ended_reg)
                begin
                    // STOP keyword
                    if ((stop_reg < udcp_pkg::STOP_DONE)
                        && (rx_byte == udcp_pkg::stop_char(stop_reg[1:0])))
                        stop_next = stop_reg + 1'b1;
                    else
                        stop_next = udcp_pkg::STOP_FAILED;

                    // V,<int>,<int> pattern
                    unique case (phase_reg)
                        PH_EXPECT_V:
                            phase_next = (rx_byte == udcp_pkg::CH_V) ? PH_EXPECT_COMMA : PH_FAILED;
                        PH_EXPECT_COMMA:
                            phase_next = (rx_byte == udcp_pkg::CH_COMMA) ? PH_LEFT_START
                                                                         : PH_FAILED;
                        PH_LEFT_START, PH_LEFT_SIGN:
                        begin
                            if ((phase_reg == PH_LEFT_START) && is_blank)
                                phase_next = PH_LEFT_START;
                            else if ((phase_reg == PH_LEFT_START) && is_sign)
                            begin
                                lneg_next  = is_minus;
                                phase_next = PH_LEFT_SIGN;
                            end
                            else if (is_digit)
                            begin
                                lmag_next  = add_digit(lmag_reg, rx_byte);
                                phase_next = PH_LEFT_DIGITS;
                            end
                            else
                                phase_next = PH_FAILED;
                        end
                        PH_LEFT_DIGITS:
                        begin
                            if (is_digit)
                                lmag_next = add_digit(lmag_reg, rx_byte);
                            else
                                phase_next = (rx_byte == udcp_pkg::CH_COMMA) ? PH_RIGHT_START
                                                                             : PH_FAILED;
                        end
                        PH_RIGHT_START, PH_RIGHT_SIGN:
                        begin
                            if ((phase_reg == PH_RIGHT_START) && is_blank)
                                phase_next = PH_RIGHT_START;
                            else if ((phase_reg == PH_RIGHT_START) && is_sign)
                            begin
                                rneg_next  = is_minus;
                                phase_next = PH_RIGHT_SIGN;
                            end
                            else if (is_digit)
                            begin
                                rmag_next  = add_digit(rmag_reg, rx_byte);
                                phase_next = PH_RIGHT_DIGITS;
                            end
                            else
                                phase_next = PH_FAILED;
                        end
                        PH_RIGHT_DIGITS:
                        begin
                            if (is_digit)
                                rmag_next = add_digit(rmag_reg, rx_byte);
                            else
                                phase_next = PH_MATCHED;
                        end
                        default:
                            phase_next = phase_reg;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_EXPECT_V;
            fill_reg  <= '0;
            lmag_reg  <= '0;
            lneg_reg  <= 1'b0;
            rmag_reg  <= '0;
            rneg_reg  <= 1'b0;
            stop_reg  <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            lmag_reg  <= lmag_next;
            lneg_reg  <= lneg_next;
            rmag_reg  <= rmag_next;
            rneg_reg  <= rneg_next;
            stop_reg  <= stop_next;
            ended_reg <= ended_next;
        end
    end

endmodule

// ----- rtl/udcp_watchdog.sv -----
// udcp_watchdog: elapsed-millisecond counter and arm flag for command loss.
// Depends on udcp_pkg for the config struct and counter width.
module udcp_watchdog (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tick,
    input  logic           cmd_ok,
    input  udcp_pkg::cfg_t cfg,
    output logic           fire
);

    logic [udcp_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic                           armed_reg, armed_next;

    // saturating increment
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        elapsed_next = elapsed_reg;
        armed_next   = armed_reg;
        fire         = 1'b0;
        if (tick)
        begin
            elapsed_next = elapsed_inc;
            if (cfg.enable && armed_reg
                && (elapsed_inc > {1'b0, cfg.timeout_ms}))
            begin
                fire       = 1'b1;
                armed_next = 1'b0;
            end
        end
        else if (cmd_ok)
        begin
            elapsed_next = '0;
            armed_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            armed_reg   <= 1'b0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            armed_reg   <= armed_next;
        end
    end

endmodule

// ----- rtl/uart_drive_command_parser_top.sv -----
// uart_drive_command_parser_top: top level of the UART drive command parser.
// Depends on udcp_pkg, udcp_if, udcp_apb_regs, udcp_line_parser, udcp_watchdog.
//
//  channel   dir   handshake        payload
//  -------   ---   ---------------  -------------------------------------------
//  in_ch     in    valid / ready    command[1:0], rx_byte[7:0]
//  out_ch    out   valid / ready    action[1:0], left_target, right_target
//  apb       in    psel / penable   paddr, pwdata, prdata (pready tied high)
//
//  One word per cycle while in_ch.ready is high: each accepted word updates the parser and watchdog
//  state in the same cycle and its result lands in the output register.
//  The result word is registered and appears on out_ch in the cycle after its input word.
//  in_ch.ready drops only while a result sits in the output register and
//  out_ch.ready is low; the output register alone sets that limit.
//  Async active-low reset returns registers to timeout 500 ms, enable 1,
//  an empty line and a disarmed watchdog.
module uart_drive_command_parser_top #(
    parameter int LINE_CAPACITY = 64,
    parameter int TARGET_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    udcp_in_if.sink                      in_ch,
    udcp_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [udcp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    udcp_pkg::cfg_t       cfg;
    udcp_pkg::parse_evt_t evt;

    logic signed [TARGET_BITS-1:0] left_tgt, right_tgt;
    logic                          take;
    logic                          tick;
    logic                          fire;
    logic                          has_result;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    action_reg, action_next;
    logic signed [TARGET_BITS-1:0] left_reg, left_next;
    logic signed [TARGET_BITS-1:0] right_reg, right_next;

    // accept whenever the output register is free or being drained
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign take        = in_ch.valid && in_ch.ready;
    assign tick        = take && (in_ch.command == udcp_pkg::CMD_TICK);

    udcp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    udcp_line_parser #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .TARGET_BITS   (TARGET_BITS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .command      (in_ch.command),
        .rx_byte      (in_ch.rx_byte),
        .evt          (evt),
        .left_target  (left_tgt),
        .right_target (right_tgt)
    );

    udcp_watchdog u_wdog (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .cmd_ok (evt.set_cmd || evt.stop_cmd),
        .cfg    (cfg),
        .fire   (fire)
    );

    // a tick word and a byte word never coincide, so at most one source fires
    assign has_result = evt.set_cmd || evt.stop_cmd || fire;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        action_next    = action_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        if (take && has_result)
        begin
            out_valid_next = 1'b1;
            left_next      = '0;
            right_next     = '0;
            if (evt.set_cmd)
            begin
                action_next = udcp_pkg::ACT_SET_TARGETS;
                left_next   = left_tgt;
                right_next  = right_tgt;
            end
            else if (evt.stop_cmd)
                action_next = udcp_pkg::ACT_STOP_CMD;
            else
                action_next = udcp_pkg::ACT_STOP_WDOG;
        end
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.action       = action_reg;
    assign out_ch.left_target  = left_reg;
    assign out_ch.right_target = right_reg;

endmodule
